@@ rtl/core/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
	localparam logic [1:0] CFG_LOW_CONFIRM   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd20;
	localparam logic [14:0] RST_TIMEOUT_TICKS = 15'd19140;
	localparam logic [5:0]  RST_LOW_CONFIRM   = 6'd30;

	// Centimeters per 58 us of echo time, kept as a running remainder
	localparam int          RANGE_DIV = 58;
	localparam int          REM_W     = 6;
	localparam logic [9:0]  DIST_MAX  = 10'd1023;
	localparam logic [7:0]  PULSE_MAX = 8'd255;
	localparam logic [5:0]  LOW_MAX   = 6'd63;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_TRIG = 5'b00010,
		PH_WAIT = 5'b00100,
		PH_HIGH = 5'b01000,
		PH_LOW  = 5'b10000
	} phase_t;

	// Timer controls from the sequencer
	typedef struct packed {
		logic clear;
		logic inc;
	} tmr_ctl_t;

	// One result beat
	typedef struct packed {
		logic [9:0] distance_cm;
		logic       timed_out;
		logic       done_res;
		logic       busy_res;
		logic       trigger;
	} res_t;

endpackage

@@ rtl/core/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: beat registers, config, sequencer.
// Depends on uer_pkg, uer_timer and uer_fsm.
//
// Each input beat is one microsecond tick carrying a start request and the
// sampled echo level; each produces exactly one output beat with the trigger
// drive, busy and done flags, the timeout flag and the last distance in cm.
// Throughput is one beat per clock while m_tready is held high: the input
// register and the result register each advance once per cycle, and all
// per-tick state (phase, trigger count, low-run count, elapsed timer) updates
// in one pass between them. A beat moves from the input register into the
// result register when the result register is free or draining. The divide
// by 58 is carried as a quotient/remainder counter stepped alongside the
// elapsed timer, so the distance is ready on the done tick with no divider.
// Configuration writes (trigger_ticks, timeout_ticks, low_confirm) are always
// taken and must only be issued while no measurement is running; writes to
// unknown indexes are dropped. The output register holds its beat under
// backpressure while the next beat waits in the input register.
module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int TIMER_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	// tick stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] trigger, [1] busy_res, [2] done_res,
	                               // [3] timed_out, [13:4] distance_cm, [15:14] zero
);

	localparam int QW = TIMER_BITS - 5;

	// config registers
	logic [7:0]  trigger_ticks_q;
	logic [14:0] timeout_ticks_q;
	logic [5:0]  low_confirm_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= RST_TRIGGER_TICKS;
			timeout_ticks_q <= RST_TIMEOUT_TICKS;
			low_confirm_q   <= RST_LOW_CONFIRM;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TRIGGER_TICKS: trigger_ticks_q <= cfg_data[7:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				CFG_LOW_CONFIRM:   low_confirm_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1, start_s1, echo_s1;
	logic out_valid_q;
	res_t out_q;
	logic step;

	// s1 moves into the result register when that register is free or draining
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			echo_s1  <= s_tdata[1];
		end
	end

	// per-tick update
	tmr_ctl_t              tmr_ctl;
	logic [TIMER_BITS-1:0] elapsed_nx;
	logic [QW-1:0]         quot_nx;
	res_t                  res;

	uer_timer #(.TIMER_BITS(TIMER_BITS), .QW(QW)) u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tmr_ctl),
		.elapsed_nx (elapsed_nx),
		.quot_nx    (quot_nx)
	);

	uer_fsm #(.TIMER_BITS(TIMER_BITS), .QW(QW)) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.start_req     (start_s1),
		.echo_level    (echo_s1),
		.trigger_ticks (trigger_ticks_q),
		.timeout_ticks (timeout_ticks_q),
		.low_confirm   (low_confirm_q),
		.elapsed_nx    (elapsed_nx),
		.quot_nx       (quot_nx),
		.tmr_ctl       (tmr_ctl),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || m_tready)
			out_valid_q <= step;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.distance_cm, out_q.timed_out, out_q.done_res,
		out_q.busy_res, out_q.trigger};

endmodule

@@ rtl/core/uer_timer.sv @@
// Echo timer: elapsed tick counter with a running quotient and remainder by 58.
// Depends on uer_pkg.
module uer_timer import uer_pkg::*; #(
	parameter int TIMER_BITS = 15,
	parameter int QW = TIMER_BITS - 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmr_ctl_t              ctl,
	output logic [TIMER_BITS-1:0] elapsed_nx,
	output logic [QW-1:0]         quot_nx
);

	localparam logic [TIMER_BITS-1:0] TMAX   = {TIMER_BITS{1'b1}};
	localparam logic [REM_W-1:0]      REM_TOP = REM_W'(RANGE_DIV - 1);

	logic [TIMER_BITS-1:0] elapsed_q;
	logic [QW-1:0]         quot_q;
	logic [REM_W-1:0]      rem_q, rem_nx;

	always_comb begin
		elapsed_nx = elapsed_q;
		quot_nx    = quot_q;
		rem_nx     = rem_q;
		if (ctl.clear) begin
			elapsed_nx = '0;
			quot_nx    = '0;
			rem_nx     = '0;
		end else if (ctl.inc && elapsed_q != TMAX) begin
			elapsed_nx = elapsed_q + 1'b1;
			if (rem_q == REM_TOP) begin
				rem_nx  = '0;
				quot_nx = quot_q + 1'b1;
			end else begin
				rem_nx = rem_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			quot_q    <= '0;
			rem_q     <= '0;
		end else begin
			elapsed_q <= elapsed_nx;
			quot_q    <= quot_nx;
			rem_q     <= rem_nx;
		end
	end

endmodule

@@ rtl/core/uer_fsm.sv @@
// Measurement sequencer: trigger pulse, echo wait, high/low tracking, result.
// Depends on uer_pkg; works with uer_timer for elapsed time.
module uer_fsm import uer_pkg::*; #(
	parameter int TIMER_BITS = 15,
	parameter int QW = TIMER_BITS - 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  start_req,
	input  logic                  echo_level,
	input  logic [7:0]            trigger_ticks,
	input  logic [14:0]           timeout_ticks,
	input  logic [5:0]            low_confirm,
	input  logic [TIMER_BITS-1:0] elapsed_nx,
	input  logic [QW-1:0]         quot_nx,
	output tmr_ctl_t              tmr_ctl,
	output res_t                  res
);

	localparam int CW = (TIMER_BITS > 15) ? TIMER_BITS : 15;
	localparam int QX = (QW > 10) ? QW : 10;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	phase_t      phase_q, phase_nx;
	logic [7:0]  pulse_q, pulse_nx;
	logic [5:0]  low_q, low_nx;
	logic [QW-1:0] travel_q, travel_nx;
	logic [9:0]  dist_q, dist_nx;
	logic        to_q, to_nx;

	logic [7:0]  trig_n;
	logic [5:0]  low_n;
	logic [7:0]  pulse_inc;
	logic [5:0]  low_inc;
	logic        trig_out, done;
	logic        hit_timeout;

	function automatic logic [9:0] sat_dist(input logic [QW-1:0] q);
		logic [QX-1:0] qe;
		qe = QX'(q);
		return (qe > QX'(DIST_MAX)) ? DIST_MAX : qe[9:0];
	endfunction

	assign trig_n    = (trigger_ticks == 8'd0) ? 8'd1 : trigger_ticks;
	assign low_n     = (low_confirm == 6'd0) ? 6'd1 : low_confirm;
	assign pulse_inc = (pulse_q < PULSE_MAX) ? pulse_q + 8'd1 : pulse_q;
	assign low_inc   = (low_q < LOW_MAX) ? low_q + 6'd1 : low_q;
	assign hit_timeout = (CW'(elapsed_nx) >= CW'(timeout_ticks)) || (elapsed_nx == TMAX);

	always_comb begin
		phase_nx  = phase_q;
		pulse_nx  = pulse_q;
		low_nx    = low_q;
		travel_nx = travel_q;
		dist_nx   = dist_q;
		to_nx     = to_q;
		trig_out  = 1'b0;
		done      = 1'b0;
		tmr_ctl   = '0;
		if (step) begin
			case (phase_q)
				PH_IDLE: begin
					if (start_req) begin
						trig_out = 1'b1;
						pulse_nx = 8'd1;
						phase_nx = (trig_n <= 8'd1) ? PH_WAIT : PH_TRIG;
					end
				end
				PH_TRIG: begin
					trig_out = 1'b1;
					pulse_nx = pulse_inc;
					if (pulse_inc >= trig_n)
						phase_nx = PH_WAIT;
				end
				PH_WAIT: begin
					if (echo_level) begin
						tmr_ctl.clear = 1'b1;
						travel_nx = '0;
						low_nx    = '0;
						phase_nx  = PH_HIGH;
						// zero timeout ends on the rise itself
						if (timeout_ticks == 15'd0) begin
							dist_nx  = '0;
							to_nx    = 1'b1;
							done     = 1'b1;
							phase_nx = PH_IDLE;
						end
					end
				end
				PH_HIGH, PH_LOW: begin
					tmr_ctl.inc = 1'b1;
					if (echo_level) begin
						travel_nx = quot_nx;
						low_nx    = '0;
						phase_nx  = PH_HIGH;
						if (hit_timeout) begin
							dist_nx  = sat_dist(quot_nx);
							to_nx    = 1'b1;
							done     = 1'b1;
							phase_nx = PH_IDLE;
						end
					end else begin
						low_nx   = low_inc;
						phase_nx = PH_LOW;
						if (low_inc >= low_n) begin
							dist_nx  = sat_dist(travel_q);
							to_nx    = 1'b0;
							done     = 1'b1;
							phase_nx = PH_IDLE;
						end
					end
				end
				default: phase_nx = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pulse_q  <= '0;
			low_q    <= '0;
			travel_q <= '0;
			dist_q   <= '0;
			to_q     <= 1'b0;
		end else begin
			phase_q  <= phase_nx;
			pulse_q  <= pulse_nx;
			low_q    <= low_nx;
			travel_q <= travel_nx;
			dist_q   <= dist_nx;
			to_q     <= to_nx;
		end
	end

	always_comb begin
		res.trigger     = trig_out;
		res.busy_res    = (phase_nx != PH_IDLE);
		res.done_res    = done;
		res.timed_out   = to_nx;
		res.distance_cm = dist_nx;
	end

endmodule

@@ tb/sv/tb_ultrasonic_echo_ranger.sv @@
// Self-checking testbench for ultrasonic_echo_ranger: a tick stream drives the ranger,
// and every result beat is checked against an in-bench model of the measurement.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL only.
module tb_ultrasonic_echo_ranger;
	import uer_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMER_BITS    = 15;
	localparam int TIMER_MAX     = (1 << TIMER_BITS) - 1;
	localparam int SETTLE_CYCLES = 8;        // pipeline is two deep, keep some margin
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_TICKS   = 40;       // per phase, plus the tail of the last measurement
	localparam int HOLD_FIRST    = 50;       // receiver hold-offs, in receiver cycles
	localparam int HOLD_SPACING  = 3000;
	localparam int HOLD_LEN      = 300;
	localparam int HOLD_MIN_TICKS = 32;      // ticks queued before a hold-off starts

	localparam logic [1:0] CFG_UNMAPPED = 2'd3;

	// one input beat: bit 0 start_req, bit 1 echo_level
	typedef struct packed {
		logic echo_level;
		logic start_req;
	} tick_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [0] start_req, [1] echo_level, [7:2] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [0] trigger, [1] busy_res, [2] done_res,
	                              // [3] timed_out, [13:4] distance_cm, [15:14] zero

	ultrasonic_echo_ranger #(.TIMER_BITS(TIMER_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Ranger model: configuration copy and measurement state
	// ---------------------------------------------------------------------
	logic [7:0]            cfg_trig    = RST_TRIGGER_TICKS;
	logic [14:0]           cfg_timeout = RST_TIMEOUT_TICKS;
	logic [5:0]            cfg_lowconf = RST_LOW_CONFIRM;

	phase_t                ph_st       = PH_IDLE;
	logic [7:0]            pulse_n     = '0;
	logic [TIMER_BITS-1:0] elapsed     = '0;
	logic [TIMER_BITS-1:0] travel      = '0;
	logic [5:0]            low_run     = '0;
	logic [9:0]            last_dist   = '0;
	logic                  last_to     = 1'b0;

	tick_t tick_q[$];         // ticks waiting to be sent
	res_t  result_due_q[$];   // results predicted for accepted ticks

	int errors = 0;
	int total_ticks = 0;
	int cfg_writes = 0;
	int done_seen = 0;
	int timeout_seen = 0;

	// Distance from travel time, saturating; ends the measurement.
	function automatic void close_measurement(logic by_timeout);
		int q;
		q = int'(travel) / RANGE_DIV;
		last_dist = (q > int'(DIST_MAX)) ? DIST_MAX : q[9:0];
		last_to = by_timeout;
		ph_st = PH_IDLE;
	endfunction

	// Advance the model by one tick and return the result beat it produces.
	function automatic res_t ranger_tick(logic start, logic echo);
		res_t r;
		logic [7:0] trig_n;
		logic [5:0] low_n;
		r = '0;
		trig_n = (cfg_trig == '0) ? 8'd1 : cfg_trig;       // zero acts as one
		low_n = (cfg_lowconf == '0) ? 6'd1 : cfg_lowconf;
		case (ph_st)
			PH_IDLE: begin
				if (start) begin
					r.trigger = 1'b1;
					pulse_n = 8'd1;
					ph_st = (pulse_n >= trig_n) ? PH_WAIT : PH_TRIG;
				end
			end
			PH_TRIG: begin
				r.trigger = 1'b1;
				if (pulse_n < PULSE_MAX)
					pulse_n++;
				if (pulse_n >= trig_n)
					ph_st = PH_WAIT;
			end
			PH_WAIT: begin
				// no limit on this wait; only a rising echo leaves it
				if (echo) begin
					elapsed = '0;
					travel = '0;
					low_run = '0;
					ph_st = PH_HIGH;
					if (travel >= cfg_timeout) begin
						close_measurement(1'b1);
						r.done_res = 1'b1;
					end
				end
			end
			PH_HIGH, PH_LOW: begin
				if (elapsed < TIMER_MAX)
					elapsed++;
				if (echo) begin
					// a high inside a low run resumes timing from the same rise
					travel = elapsed;
					low_run = '0;
					ph_st = PH_HIGH;
					if (travel >= cfg_timeout || elapsed == TIMER_MAX) begin
						close_measurement(1'b1);
						r.done_res = 1'b1;
					end
				end else begin
					if (low_run < LOW_MAX)
						low_run++;
					ph_st = PH_LOW;
					if (low_run >= low_n) begin
						close_measurement(1'b0);
						r.done_res = 1'b1;
					end
				end
			end
			default: ph_st = PH_IDLE;
		endcase
		r.busy_res = (ph_st != PH_IDLE);
		r.timed_out = last_to;
		r.distance_cm = last_dist;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them
	// ---------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// beat taken at this edge: run the model on it
			if (s_tvalid && s_tready)
				result_due_q.push_back(ranger_tick(s_tdata[0], s_tdata[1]));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, tick_q.pop_front()};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// mostly short bursts, now and then a long unbroken run
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
						                                        : $urandom_range(1, 30);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: a randomly chosen stall pattern, plus long hold-offs while
	// ticks are queued so the input side has to back up
	// ---------------------------------------------------------------------
	int rx_cycles = 0;
	int rx_mode = 0;
	int hold_left = 0;
	int hold_at = HOLD_FIRST;

	always @(posedge clk) begin
		rx_cycles++;
		if (rx_cycles % 128 == 0)
			rx_mode = $urandom_range(0, 3);
		if (hold_left == 0 && rx_cycles >= hold_at && tick_q.size() > HOLD_MIN_TICKS) begin
			hold_left = HOLD_LEN;
			hold_at = rx_cycles + HOLD_SPACING;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycles % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: each result beat against the oldest prediction
	// ---------------------------------------------------------------------
	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[13:0]);
			if (result_due_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h",
				         $time, m_tdata);
				errors++;
			end else begin
				want = result_due_q.pop_front();
				check_field("trigger", int'(want.trigger), int'(got.trigger));
				check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
				check_field("done_res", int'(want.done_res), int'(got.done_res));
				check_field("timed_out", int'(want.timed_out), int'(got.timed_out));
				check_field("distance_cm", int'(want.distance_cm), int'(got.distance_cm));
				if (want.done_res) begin
					done_seen++;
					if (want.timed_out)
						timeout_seen++;
				end
			end
		end
	end

	// Run limit
	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit reached, %0d results still due", $time,
			         result_due_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic void add_tick(logic start, logic echo);
		tick_t t;
		t.start_req = start;
		t.echo_level = echo;
		tick_q.push_back(t);
		total_ticks++;
	endfunction

	function automatic void add_ticks(int n, logic start, logic echo);
		repeat (n) add_tick(start, echo);
	endfunction

	// Wait until every queued tick is sent and every result has come back.
	task automatic settle();
		do @(posedge clk);
		while (tick_q.size() != 0 || s_tvalid || result_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Feed ticks until the model is idle, so config writes hit an idle block.
	task automatic go_idle();
		settle();
		while (ph_st != PH_IDLE) begin
			case (ph_st)
				PH_WAIT: add_tick(1'b0, 1'b1);     // raise echo to leave the wait
				PH_TRIG: add_tick(1'b0, 1'b0);
				default: add_ticks(64, 1'b0, 1'b0); // more lows than any confirm count
			endcase
			settle();
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TRIGGER_TICKS: cfg_trig = val[7:0];
			CFG_TIMEOUT_TICKS: cfg_timeout = val;
			CFG_LOW_CONFIRM:   cfg_lowconf = val[5:0];
			default: ;                         // unknown index is dropped
		endcase
		cfg_writes++;
	endtask

	task automatic write_all(logic [7:0] trig, logic [14:0] tmo, logic [5:0] lowc);
		// junk in the unused upper bits must be ignored
		write_reg(CFG_TRIGGER_TICKS, {7'($urandom_range(0, 127)), trig});
		write_reg(CFG_TIMEOUT_TICKS, tmo);
		write_reg(CFG_LOW_CONFIRM, {9'($urandom_range(0, 511)), lowc});
	endtask

	// One random measurement under the current settings. Most are well formed:
	// start, trigger, short wait, echo with glitches, confirmed low. A few are
	// cut short, and a few are plain noise.
	task automatic add_measurement();
		int trig_n;
		int low_n;
		int span;
		int pick;
		trig_n = (cfg_trig == '0) ? 1 : int'(cfg_trig);
		low_n = (cfg_lowconf == '0) ? 1 : int'(cfg_lowconf);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 20))
				add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			add_tick(1'b1, 1'($urandom_range(0, 1)));
			// echo and start are don't-cares while the trigger is high
			repeat (trig_n - 1)
				add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 6))
				add_tick(1'($urandom_range(0, 1)), 1'b0);
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					span = $urandom_range(1, 40);
				else if (pick < 19)
					span = $urandom_range(40, 250);
				else
					span = $urandom_range(int'(cfg_timeout), int'(cfg_timeout) + 10);
				repeat (span)
					add_tick($urandom_range(0, 15) == 0, 1'b1);
				// low glitch shorter than the confirm count
				if (low_n > 1)
					add_ticks($urandom_range(1, low_n - 1), 1'b0, 1'b0);
			end
			if ($urandom_range(0, 7) != 0)
				add_ticks(low_n + $urandom_range(0, 3), 1'b0, 1'b0);
		end
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		int mark;
		logic [7:0] trig;
		logic [14:0] tmo;
		logic [5:0] lowc;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: echo and start during the trigger are ignored, start
		// while waiting is ignored, a short low glitch resumes timing.
		add_ticks(3, 1'b0, 1'b0);
		add_tick(1'b1, 1'b1);
		add_ticks(19, 1'b1, 1'b1);
		add_ticks(5, 1'b1, 1'b0);
		add_ticks(100, 1'b0, 1'b1);
		add_ticks(29, 1'b0, 1'b0);
		add_ticks(60, 1'b1, 1'b1);
		add_ticks(32, 1'b0, 1'b0);
		go_idle();

		// Longest trigger and confirm count, echo held past the timeout.
		write_all(8'd255, 15'd150, 6'd63);
		add_tick(1'b1, 1'b0);
		add_ticks(254, 1'b0, 1'b1);
		add_ticks(190, 1'b0, 1'b1);
		go_idle();

		// Zero settings: trigger and confirm act as one, the rise tick times out.
		write_all(8'd0, 15'd0, 6'd0);
		write_reg(CFG_UNMAPPED, 15'($urandom_range(0, 32767)));
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		add_ticks(2, 1'b0, 1'b0);
		go_idle();
		write_reg(CFG_TIMEOUT_TICKS, 15'd5);
		add_tick(1'b1, 1'b1);
		add_ticks(2, 1'b0, 1'b1);
		add_ticks(2, 1'b0, 1'b0);
		go_idle();

		// Smallest legal settings: timeout one tick after the rise.
		write_all(8'd1, 15'd1, 6'd1);
		add_tick(1'b1, 1'b0);
		add_ticks(3, 1'b0, 1'b1);
		add_ticks(2, 1'b0, 1'b0);
		go_idle();

		// Random part, one batch per random setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			trig = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 40))
			                                   : 8'($urandom_range(1, 10));
			tmo = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(0, 30))
			                                  : 15'($urandom_range(30, 400));
			lowc = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
			                                   : 6'($urandom_range(1, 12));
			write_all(trig, tmo, lowc);
			mark = total_ticks;
			while (total_ticks - mark < PHASE_TICKS)
				add_measurement();
			go_idle();
		end

		settle();
		if (result_due_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, result_due_q.size());
			errors++;
		end

		$display("Sent %0d ticks over %0d register writes; %0d measurements finished,",
		         total_ticks, cfg_writes, done_seen);
		$display("%0d of them by timeout; %0d field mismatches.", timeout_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
